// ===== rtl/uwsc_pkg.sv =====
// Package for the UTF-8 whitespace string check.
// Holds the decoder state type, lead byte codes and the whitespace code point test.
// No dependencies.
package uwsc_pkg;

  localparam int CodeWidth = 21;

  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Code = 8'hc0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Code = 8'he0;
  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Code = 8'hf0;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContCode  = 8'h80;

  localparam logic [CodeWidth-1:0] CpTab       = 21'h00009;
  localparam logic [CodeWidth-1:0] CpCr        = 21'h0000d;
  localparam logic [CodeWidth-1:0] CpSpace     = 21'h00020;
  localparam logic [CodeWidth-1:0] CpNextLine  = 21'h00085;
  localparam logic [CodeWidth-1:0] CpNbsp      = 21'h000a0;
  localparam logic [CodeWidth-1:0] CpOgham     = 21'h01680;
  localparam logic [CodeWidth-1:0] CpEnQuad    = 21'h02000;
  localparam logic [CodeWidth-1:0] CpHairSpace = 21'h0200a;
  localparam logic [CodeWidth-1:0] CpLineSep   = 21'h02028;
  localparam logic [CodeWidth-1:0] CpParaSep   = 21'h02029;
  localparam logic [CodeWidth-1:0] CpNarrowNb  = 21'h0202f;
  localparam logic [CodeWidth-1:0] CpMathSpace = 21'h0205f;
  localparam logic [CodeWidth-1:0] CpIdeoSpace = 21'h03000;

  typedef struct packed {
    logic [1:0]           pending;
    logic [CodeWidth-1:0] acc;
    logic                 failed;
  } uwsc_state_t;

  function automatic logic is_space_code(input logic [CodeWidth-1:0] c);
    is_space_code = (c >= CpTab && c <= CpCr) || c == CpSpace || c == CpNextLine ||
                    c == CpNbsp || c == CpOgham || (c >= CpEnQuad && c <= CpHairSpace) ||
                    c == CpLineSep || c == CpParaSep || c == CpNarrowNb ||
                    c == CpMathSpace || c == CpIdeoSpace;
  endfunction

endpackage

// ===== rtl/uwsc_if.sv =====
// Channel interfaces for the UTF-8 whitespace string check.
// One interface for the byte stream and one for the verdict; no dependencies.
interface uwsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;
  logic       empty_string;

  modport source(output valid, output data_byte, output end_of_string,
                 output empty_string, input ready);
  modport sink(input valid, input data_byte, input end_of_string,
               input empty_string, output ready);
endinterface

interface uwsc_verdict_if;
  logic valid;
  logic ready;
  logic all_whitespace;

  modport source(output valid, output all_whitespace, input ready);
  modport sink(input valid, input all_whitespace, output ready);
endinterface

// ===== rtl/utf8_whitespace_string_check.sv =====
// Top level of the UTF-8 whitespace string check.
// Depends on uwsc_pkg, uwsc_if and uwsc_step.
//
// Bytes of a string arrive one per transaction; the item flagged end_of_string gives one
// verdict transaction, which is 1 when the string is empty or decodes to whitespace only.
// The block takes one byte per cycle. A byte passes an input register and then updates the
// decoder state; at that same edge an end item loads its verdict into the output register, so
// a verdict becomes valid once its end item has left the input register. The output register
// holds a verdict until it is taken while later bytes keep flowing; only an end item waits
// while an untaken verdict occupies the output register.
module utf8_whitespace_string_check (
  input logic            clk,
  input logic            rst,
  uwsc_byte_if.sink      bytes,
  uwsc_verdict_if.source verdict
);
  import uwsc_pkg::*;

  logic        in_q_valid;
  logic [7:0]  in_q_byte;
  logic        in_q_end;
  logic        in_q_empty;
  uwsc_state_t state;
  uwsc_state_t state_next;
  logic        out_valid;
  logic        out_bit;
  logic        out_free;
  logic        fire;

  assign out_free = !out_valid || verdict.ready;
  assign fire     = in_q_valid && (!in_q_end || out_free);
  assign bytes.ready = !in_q_valid || fire;

  assign verdict.valid          = out_valid;
  assign verdict.all_whitespace = out_bit;

  uwsc_step u_step (
    .cur          (state),
    .data_byte    (in_q_byte),
    .empty_string (in_q_empty),
    .nxt          (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_q_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_q_byte  <= bytes.data_byte;
      in_q_end   <= bytes.end_of_string;
      in_q_empty <= bytes.empty_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= in_q_end ? '0 : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_q_end) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_q_end) begin
      out_bit <= !state_next.failed && state_next.pending == 2'd0;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    fire && in_q_end |=> state.pending == 2'd0 && !state.failed)
    else $error("decoder state not cleared after end of string");

  a_failed_gives_false: assert property (@(posedge clk) disable iff (rst)
    fire && in_q_end && state.failed |=> verdict.valid && !verdict.all_whitespace)
    else $error("failed string produced a true verdict");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !bytes.ready |-> in_q_valid && in_q_end && out_valid)
    else $error("input stalled without a blocked end item");
`endif
endmodule

// ===== rtl/uwsc_step.sv =====
// Next-state logic of the UTF-8 decoder for one byte.
// Depends on uwsc_pkg.
module uwsc_step (
  input  uwsc_pkg::uwsc_state_t cur,
  input  logic [7:0]            data_byte,
  input  logic                  empty_string,
  output uwsc_pkg::uwsc_state_t nxt
);
  import uwsc_pkg::*;

  logic [CodeWidth-1:0] acc_shift;

  assign acc_shift = {cur.acc[CodeWidth-7:0], data_byte[5:0]};

  always_comb begin
    nxt = cur;
    if (!empty_string && !cur.failed) begin
      if (cur.pending == 2'd0) begin
        priority if (!data_byte[7]) begin
          nxt.failed = !is_space_code(CodeWidth'(data_byte));
        end else if ((data_byte & Lead2Mask) == Lead2Code) begin
          nxt.acc     = CodeWidth'(data_byte[4:0]);
          nxt.pending = 2'd1;
        end else if ((data_byte & Lead3Mask) == Lead3Code) begin
          nxt.acc     = CodeWidth'(data_byte[3:0]);
          nxt.pending = 2'd2;
        end else if ((data_byte & Lead4Mask) == Lead4Code) begin
          nxt.acc     = CodeWidth'(data_byte[2:0]);
          nxt.pending = 2'd3;
        end else begin
          nxt.failed = 1'b1;
        end
      end else if ((data_byte & ContMask) != ContCode) begin
        nxt.failed = 1'b1;
      end else begin
        nxt.acc     = acc_shift;
        nxt.pending = cur.pending - 2'd1;
        if (cur.pending == 2'd1 && !is_space_code(acc_shift)) begin
          nxt.failed = 1'b1;
        end
      end
    end
  end
endmodule

// ===== tb/sv/uwsc_whitespace_checker.sv =====
`timescale 1ns / 100ps
// Checker for the UTF-8 whitespace string check: watches the byte and verdict channels,
// decodes each accepted string itself and compares every verdict with its own prediction.
// Depends on uwsc_pkg and uwsc_if.
module uwsc_whitespace_checker (
  input  logic    clk,
  input  logic    rst,
  uwsc_byte_if    bytes,
  uwsc_verdict_if verdict,
  output int      mismatch_count,
  output int      verdicts_owed
);
  import uwsc_pkg::*;

  logic [1:0]           cont_left;
  logic [CodeWidth-1:0] code_acc;
  logic                 text_bad;
  bit                   expected_verdicts[$];

  function automatic bit is_blank_cp(input logic [CodeWidth-1:0] c);
    return (c >= CpTab && c <= CpCr) || c == CpSpace || c == CpNextLine || c == CpNbsp ||
           c == CpOgham || (c >= CpEnQuad && c <= CpHairSpace) || c == CpLineSep ||
           c == CpParaSep || c == CpNarrowNb || c == CpMathSpace || c == CpIdeoSpace;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    if (text_bad) return;
    if (cont_left == 2'd0) begin
      if (!b[7]) begin
        if (!is_blank_cp({13'd0, b})) text_bad = 1'b1;
      end else if ((b & Lead2Mask) == Lead2Code) begin
        code_acc  = {16'd0, b[4:0]};
        cont_left = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        code_acc  = {17'd0, b[3:0]};
        cont_left = 2'd2;
      end else if ((b & Lead4Mask) == Lead4Code) begin
        code_acc  = {18'd0, b[2:0]};
        cont_left = 2'd3;
      end else begin
        text_bad = 1'b1;
      end
    end else if ((b & ContMask) != ContCode) begin
      text_bad = 1'b1;
    end else begin
      code_acc  = {code_acc[CodeWidth-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0 && !is_blank_cp(code_acc)) text_bad = 1'b1;
    end
  endtask

  task automatic note_failure(input string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      cont_left = 2'd0;
      code_acc  = '0;
      text_bad  = 1'b0;
      expected_verdicts.delete();
      mismatch_count = 0;
    end else begin
      if (verdict.valid && verdict.ready) begin
        if (expected_verdicts.size() == 0) begin
          note_failure($sformatf("unexpected verdict %0b with none pending",
                                 verdict.all_whitespace));
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict.all_whitespace !== want)
            note_failure($sformatf("verdict mismatch: expected %0b, got %0b",
                                   want, verdict.all_whitespace));
        end
      end
      if (bytes.valid && bytes.ready) begin
        if (!bytes.empty_string) absorb_byte(bytes.data_byte);
        if (bytes.end_of_string) begin
          want = !text_bad && cont_left == 2'd0;
          expected_verdicts = {expected_verdicts, want};
          cont_left = 2'd0;
          code_acc  = '0;
          text_bad  = 1'b0;
        end
      end
    end
    verdicts_owed <= expected_verdicts.size();
  end

endmodule

// ===== tb/sv/tb_utf8_whitespace_string_check.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the UTF-8 whitespace string check: clock, reset, string
// stimulus with random idling on both channels, watchdog and verdict.
// Depends on uwsc_pkg, uwsc_if, utf8_whitespace_string_check and uwsc_whitespace_checker.
module tb_utf8_whitespace_string_check;
  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 410;

  logic        clk;
  logic        rst;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          items_sent;
  int          quiet_cycles;
  int          mismatch_count;
  int          verdicts_owed;
  logic [7:0]  text[$];

  uwsc_byte_if    byte_ch ();
  uwsc_verdict_if verdict_ch ();

  utf8_whitespace_string_check dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .verdict(verdict_ch)
  );

  uwsc_whitespace_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .bytes         (byte_ch),
    .verdict       (verdict_ch),
    .mismatch_count(mismatch_count),
    .verdicts_owed (verdicts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) verdict_ch.ready <= 1'b0;
    else verdict_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eos, input logic emp);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_string <= eos;
    byte_ch.empty_string  <= emp;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    if (!emp || eos) items_sent++;
  endtask

  task automatic send_text(input bit close_by_empty, input int ignored_pct);
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(99) < ignored_pct) send_item(8'($urandom), 1'b0, 1'b1);
      send_item(text[i], (i == text.size() - 1) && !close_by_empty, 1'b0);
    end
    if (close_by_empty || text.size() == 0) send_item(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic drain_verdicts();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
  endtask

  function automatic int min_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  function automatic logic [20:0] pick_blank();
    case ($urandom_range(10))
      0: return 21'($urandom_range(9, 13));
      1: return 21'h20;
      2: return 21'h85;
      3: return 21'ha0;
      4: return 21'h1680;
      5: return 21'($urandom_range(21'h2000, 21'h200a));
      6: return 21'h2028;
      7: return 21'h2029;
      8: return 21'h202f;
      9: return 21'h205f;
      default: return 21'h3000;
    endcase
  endfunction

  function automatic logic [20:0] pick_odd();
    case ($urandom_range(5))
      0: return 21'($urandom);
      1: return 21'h08 + 21'(6 * $urandom_range(1));
      2: return 21'h1f + 21'(2 * $urandom_range(1));
      3: return 21'h200b;
      4: return 21'h2027 + 21'(3 * $urandom_range(1));
      default: return 21'h3001;
    endcase
  endfunction

  task automatic append_byte(input logic [7:0] b);
    text = {text, b};
  endtask

  task automatic add_cp(input logic [20:0] cp, input int len);
    case (len)
      1: append_byte({1'b0, cp[6:0]});
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic make_text();
    logic [20:0] cp;
    int          len;
    text.delete();
    if ($urandom_range(99) < 72) begin
      repeat ($urandom_range(1, 6)) begin
        cp  = pick_blank();
        len = min_len(cp);
        if ($urandom_range(99) < 20) len = $urandom_range(len, 4);
        add_cp(cp, len);
      end
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(2))
          0: begin
            cp = pick_odd();
            add_cp(cp, min_len(cp));
            repeat ($urandom_range(1)) add_cp(pick_blank(), 3);
          end
          1: text[$urandom_range(text.size() - 1)] = 8'($urandom);
          default: text.delete(text.size() - 1);
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
    end
  endtask

  initial begin
    rst                      = 1'b1;
    byte_ch.valid            = 1'b0;
    byte_ch.data_byte        = 8'h00;
    byte_ch.end_of_string    = 1'b0;
    byte_ch.empty_string     = 1'b0;
    items_sent               = 0;
    send_idle_pct            = 19;
    recv_stall_pct           = 84;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_item(8'h5a, 1'b1, 1'b1);
    text = '{8'h20};                      send_text(1'b0, 0);
    text = '{8'h09, 8'h0d};               send_text(1'b0, 0);
    text = '{8'h08};                      send_text(1'b0, 0);
    text = '{8'hc2, 8'h85};               send_text(1'b0, 0);
    text = '{8'he3, 8'h80, 8'h80};        send_text(1'b0, 0);
    text = '{8'hf0, 8'h80, 8'h80, 8'ha0}; send_text(1'b0, 0);
    text = '{8'hff};                      send_text(1'b0, 0);
    text = '{8'hc2, 8'h41};               send_text(1'b0, 0);
    text = '{8'he2, 8'h80};               send_text(1'b0, 0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h20, 1'b1, 1'b0);
    text = '{8'h0a};                      send_text(1'b1, 0);
    text = '{8'h41, 8'h20};               send_text(1'b0, 0);
    drain_verdicts();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 19;
          recv_stall_pct = 84;
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 19;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int goal = items_sent + PhaseItems; items_sent < goal; ) begin
        if ($urandom_range(99) < 8) begin
          send_item(8'($urandom), 1'b1, 1'b1);
        end else begin
          make_text();
          send_text($urandom_range(99) < 10, 3);
        end
      end
      drain_verdicts();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/uwsc_pkg.sv
rtl/uwsc_if.sv
rtl/uwsc_step.sv
rtl/utf8_whitespace_string_check.sv
tb/sv/uwsc_whitespace_checker.sv
tb/sv/tb_utf8_whitespace_string_check.sv
